// ===== sv/ecsp_pkg.sv =====
// shared types, constants and codes for the eight channel servo pwm core
package ecsp_pkg;

	// defaults for the top level parameters
	localparam int ChannelsDef = 8;
	localparam int MaxWidthDef = 250;

	// value store: eight servo slots plus the led slot
	localparam int SlotCount = 9;
	localparam int ServoSlots = 8;
	localparam int LedIndex = 8;

	// byte that always sends the parser back to waiting for an index
	localparam logic [7:0] ResyncByte = 8'd252;

	// configuration register reset values
	localparam logic [11:0] HighTicksRst = 12'd250;
	localparam logic [12:0] LowTicksRst = 13'd4500;

	// configuration register indexes (paddr[2])
	localparam logic RegHighTicks = 1'b0;
	localparam logic RegLowTicks = 1'b1;

	// frame_phase codes on the result word
	localparam logic [1:0] FpHigh = 2'd0;
	localparam logic [1:0] FpVar = 2'd1;
	localparam logic [1:0] FpLow = 2'd2;

	typedef logic [7:0] chan_val_t;
	typedef chan_val_t [SlotCount-1:0] chan_vals_t;

	// frame state machine
	typedef enum logic [2:0] {
		PH_HIGH = 3'b001,
		PH_VAR  = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	// result word as seen after one item
	typedef struct packed {
		logic [7:0] servo_pins;
		logic       led_pin;
		logic [1:0] frame_phase;
	} frame_out_t;

endpackage

// ===== sv/eight_channel_servo_pwm_core.sv =====
// eight channel servo pwm core: byte-pair value writes and tick-driven frames
// a word moves from the input register to the result register whenever the latter frees
// throughput: one word per cycle while the result register is empty or result_ready is high
// each word updates the parser (cmd low) or the frame state (cmd high) from the input register
// reset (arst_n low, asynchronous): low phase, count zero, all channels disabled, led off,
// high_ticks 250 and low_ticks 4500, both word registers empty
module eight_channel_servo_pwm_core #(
	parameter int CHANNELS = ecsp_pkg::ChannelsDef,
	parameter int MAX_WIDTH = ecsp_pkg::MaxWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        cmd,
	input  logic [7:0]  bus_byte,
	// result words
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  servo_pins,
	output logic        led_pin,
	output logic [1:0]  frame_phase,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                 valid_s1, cmd_s1;
	logic [7:0]           byte_s1;
	logic                 adv;
	logic                 valid_s2;
	ecsp_pkg::frame_out_t out_s2, frame_nxt;
	ecsp_pkg::chan_vals_t chan_vals;
	logic [11:0]          high_ticks_q;
	logic [12:0]          low_ticks_q;
	logic                 cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_ticks_q <= ecsp_pkg::HighTicksRst;
			low_ticks_q <= ecsp_pkg::LowTicksRst;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ecsp_pkg::RegHighTicks: high_ticks_q <= pwdata[11:0];
				ecsp_pkg::RegLowTicks:  low_ticks_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ecsp_pkg::RegHighTicks: prdata = {20'd0, high_ticks_q};
			ecsp_pkg::RegLowTicks:  prdata = {19'd0, low_ticks_q};
			default:                prdata = 32'd0;
		endcase
	end

	// input register
	assign adv = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1 <= cmd;
			byte_s1 <= bus_byte;
		end
	end

	ecsp_parser #(
		.CHANNELS (CHANNELS),
		.MAX_WIDTH(MAX_WIDTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv && !cmd_s1),
		.bus_byte (byte_s1),
		.chan_vals(chan_vals)
	);

	ecsp_frame #(
		.CHANNELS (CHANNELS),
		.MAX_WIDTH(MAX_WIDTH)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (adv && cmd_s1),
		.high_ticks(high_ticks_q),
		.low_ticks (low_ticks_q),
		.chan_vals (chan_vals),
		.frame_nxt (frame_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s2 <= frame_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign servo_pins = out_s2.servo_pins;
	assign led_pin = out_s2.led_pin;
	assign frame_phase = out_s2.frame_phase;

endmodule

// ===== sv/ecsp_parser.sv =====
// byte-pair parser and channel value store
module ecsp_parser #(
	parameter int CHANNELS = ecsp_pkg::ChannelsDef,
	parameter int MAX_WIDTH = ecsp_pkg::MaxWidthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         bus_byte,
	output ecsp_pkg::chan_vals_t chan_vals
);

	localparam logic [7:0] DisabledVal = 8'(MAX_WIDTH + 1);

	logic                 expect_q;
	logic [7:0]           target_q;
	ecsp_pkg::chan_vals_t vals_q;

	// index/value state machine, resync byte wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b0;
			target_q <= 8'd0;
		end else if (step) begin
			if (!expect_q) begin
				target_q <= bus_byte;
				expect_q <= 1'b1;
			end else begin
				expect_q <= 1'b0;
			end
			if (bus_byte == ecsp_pkg::ResyncByte) begin
				expect_q <= 1'b0;
			end
		end
	end

	// value writes, only to used servo slots and the led slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ecsp_pkg::SlotCount; k++) begin
				vals_q[k] <= (k == ecsp_pkg::LedIndex) ? 8'd0 : DisabledVal;
			end
		end else if (step && expect_q) begin
			for (int k = 0; k < ecsp_pkg::SlotCount; k++) begin
				if ((k == ecsp_pkg::LedIndex || k < CHANNELS) && target_q == 8'(k)) begin
					vals_q[k] <= bus_byte;
				end
			end
		end
	end

	assign chan_vals = vals_q;

endmodule

// ===== sv/ecsp_frame.sv =====
// frame phase sequencer, snapshot registers and pin compare
module ecsp_frame #(
	parameter int CHANNELS = ecsp_pkg::ChannelsDef,
	parameter int MAX_WIDTH = ecsp_pkg::MaxWidthDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic [11:0]          high_ticks,
	input  logic [12:0]          low_ticks,
	input  ecsp_pkg::chan_vals_t chan_vals,
	output ecsp_pkg::frame_out_t frame_nxt
);

	localparam logic [7:0] DisabledVal = 8'(MAX_WIDTH + 1);
	localparam logic [12:0] VarLast = 13'(MAX_WIDTH);

	ecsp_pkg::phase_t phase_q, phase_d;
	logic [12:0]      cnt_q, cnt_d, cnt_inc;
	logic             snap;
	logic [7:0]       shadow_q [ecsp_pkg::ServoSlots];
	logic [7:0]       mask_q, mask_snap;
	logic             led_q, led_d;
	logic [7:0]       cmp;

	assign cnt_inc = cnt_q + 13'd1;

	// phase transitions on a tick
	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		snap = 1'b0;
		if (tick) begin
			cnt_d = cnt_inc;
			unique case (phase_q)
				ecsp_pkg::PH_HIGH: begin
					if (cnt_inc >= {1'b0, high_ticks}) begin
						phase_d = ecsp_pkg::PH_VAR;
						cnt_d = 13'd0;
					end
				end
				ecsp_pkg::PH_VAR: begin
					if (cnt_inc > VarLast) begin
						phase_d = ecsp_pkg::PH_LOW;
						cnt_d = 13'd0;
						snap = 1'b1;
					end
				end
				ecsp_pkg::PH_LOW: begin
					if (cnt_inc >= low_ticks) begin
						phase_d = ecsp_pkg::PH_HIGH;
						cnt_d = 13'd0;
					end
				end
				default: begin
					phase_d = ecsp_pkg::PH_LOW;
					cnt_d = 13'd0;
				end
			endcase
		end
	end

	// enable mask taken from the live values
	always_comb begin
		for (int j = 0; j < ecsp_pkg::ServoSlots; j++) begin
			mask_snap[j] = (j < CHANNELS) && (chan_vals[j] <= 8'(MAX_WIDTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ecsp_pkg::PH_LOW;
			cnt_q <= 13'd0;
			mask_q <= 8'd0;
			led_q <= 1'b0;
			for (int j = 0; j < ecsp_pkg::ServoSlots; j++) begin
				shadow_q[j] <= DisabledVal;
			end
		end else begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			if (snap) begin
				mask_q <= mask_snap;
				led_q <= chan_vals[ecsp_pkg::LedIndex][0];
				for (int j = 0; j < ecsp_pkg::ServoSlots; j++) begin
					shadow_q[j] <= chan_vals[j];
				end
			end
		end
	end

	// slot compare against the shadow values
	always_comb begin
		for (int j = 0; j < ecsp_pkg::ServoSlots; j++) begin
			cmp[j] = cnt_d < {5'd0, shadow_q[j]};
		end
	end

	assign led_d = snap ? chan_vals[ecsp_pkg::LedIndex][0] : led_q;

	// outputs as they stand after this item
	always_comb begin
		frame_nxt.led_pin = led_d;
		unique case (phase_d)
			ecsp_pkg::PH_HIGH: begin
				frame_nxt.servo_pins = mask_q;
				frame_nxt.frame_phase = ecsp_pkg::FpHigh;
			end
			ecsp_pkg::PH_VAR: begin
				frame_nxt.servo_pins = cmp & mask_q;
				frame_nxt.frame_phase = ecsp_pkg::FpVar;
			end
			ecsp_pkg::PH_LOW: begin
				frame_nxt.servo_pins = 8'd0;
				frame_nxt.frame_phase = ecsp_pkg::FpLow;
			end
			default: begin
				frame_nxt.servo_pins = 8'd0;
				frame_nxt.frame_phase = ecsp_pkg::FpLow;
			end
		endcase
	end

endmodule
